// File: sv/bba_pkg.sv
// Shared constants, codes and beat types of the buddy block allocator.
`default_nettype none
package bba_pkg;

    // Address window and block geometry.
    localparam int ADDR_BITS      = 20;
    localparam int MIN_BLOCK_LOG2 = 4;
    localparam int SIZE_BITS      = ADDR_BITS + 1;
    localparam int NODE_BITS      = ADDR_BITS - MIN_BLOCK_LOG2 + 1;
    localparam int ORD_BITS       = 5;

    // Mark store: one bit per tree node, packed into words.
    localparam int WORD_LOG2 = 5;
    localparam int WORD_BITS = 1 << WORD_LOG2;
    localparam int ROW_BITS  = NODE_BITS - WORD_LOG2;
    localparam int ROWS      = 1 << ROW_BITS;

    // Operation codes.
    localparam logic [1:0] OP_REBUILD = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;

    // Configuration register indexes.
    localparam logic REG_POOL_START = 1'b0;
    localparam logic REG_POOL_END   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [SIZE_BITS-1:0] POOL_START_RST = 21'd0;
    localparam logic [SIZE_BITS-1:0] POOL_END_RST   = 21'd1048576;

    typedef struct packed {
        logic [1:0]           operation;
        logic [SIZE_BITS-1:0] request_size;
        logic [ADDR_BITS-1:0] block_address;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] result_address;
        logic                 status;
        logic [SIZE_BITS-1:0] allocated_total;
        logic [31:0]          requested_total;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic clr_start;
        logic clr_step;
        logic rb_init;
        logic rb_ord_start;
        logic rb_grow;
        logic rb_advance;
        logic set_node;
        logic set_write;
        logic rd_scan;
        logic scan_init;
        logic scan_next_row;
        logic scan_next_level;
        logic scan_take;
        logic al_take;
        logic split_step;
        logic fr_init;
        logic fr_merge;
        logic tot_alloc;
        logic tot_free;
        logic fail;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       cls_big;
        logic       rb_more;
        logic       rb_grow;
        logic       hit;
        logic       row_last;
        logic       ord_top;
        logic       split_more;
        logic       buddy_free;
        logic       clr_last;
    } sts_t;

endpackage
`default_nettype wire

// File: sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/bba_ctrl.sv
// Sequencing state machine of the buddy block allocator.
`default_nettype none
module bba_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire bba_pkg::sts_t sts,
    output bba_pkg::cmd_t      cmd
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_RB_INIT  = 5'd2;
    localparam logic [4:0] S_RB_TEST  = 5'd3;
    localparam logic [4:0] S_RB_ORD   = 5'd4;
    localparam logic [4:0] S_SET_RD   = 5'd5;
    localparam logic [4:0] S_SET_WR   = 5'd6;
    localparam logic [4:0] S_AL_CHK   = 5'd7;
    localparam logic [4:0] S_SC_RD    = 5'd8;
    localparam logic [4:0] S_SC_CK    = 5'd9;
    localparam logic [4:0] S_AL_TAKE  = 5'd10;
    localparam logic [4:0] S_AL_SPLIT = 5'd11;
    localparam logic [4:0] S_FR_CHK   = 5'd12;
    localparam logic [4:0] S_FR_TEST  = 5'd13;
    localparam logic [4:0] S_FR_RD    = 5'd14;
    localparam logic [4:0] S_FR_CK    = 5'd15;
    localparam logic [4:0] S_FINISH   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       clr_rb_reg, clr_rb_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and command decode.
    always_comb begin
        state_next  = state_reg;
        clr_rb_next = clr_rb_reg;
        cmd         = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = clr_rb_reg ? S_RB_INIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    case (sts.op)
                        bba_pkg::OP_REBUILD: begin
                            cmd.clr_start = 1'b1;
                            clr_rb_next   = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        bba_pkg::OP_ALLOC: state_next = S_AL_CHK;
                        bba_pkg::OP_FREE:  state_next = S_FR_CHK;
                        default:           state_next = S_FINISH;
                    endcase
                end
            end
            S_RB_INIT: begin
                cmd.rb_init = 1'b1;
                state_next  = S_RB_TEST;
            end
            S_RB_TEST: begin
                if (sts.rb_more) begin
                    cmd.rb_ord_start = 1'b1;
                    state_next       = S_RB_ORD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_RB_ORD: begin
                if (sts.rb_grow) begin
                    cmd.rb_grow = 1'b1;
                end else begin
                    cmd.set_node = 1'b1;
                    state_next   = S_SET_RD;
                end
            end
            S_SET_RD: begin
                state_next = S_SET_WR;
            end
            S_SET_WR: begin
                cmd.set_write = 1'b1;
                case (sts.op)
                    bba_pkg::OP_REBUILD: begin
                        cmd.rb_advance = 1'b1;
                        state_next     = S_RB_TEST;
                    end
                    bba_pkg::OP_ALLOC: state_next = S_AL_SPLIT;
                    default: begin
                        cmd.tot_free = 1'b1;
                        state_next   = S_FINISH;
                    end
                endcase
            end
            S_AL_CHK: begin
                if (sts.cls_big) begin
                    cmd.fail   = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SC_RD;
                end
            end
            S_SC_RD: begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SC_CK;
            end
            S_SC_CK: begin
                if (sts.hit) begin
                    cmd.scan_take = 1'b1;
                    state_next    = S_AL_TAKE;
                end else if (!sts.row_last) begin
                    cmd.scan_next_row = 1'b1;
                    state_next        = S_SC_RD;
                end else if (sts.ord_top) begin
                    cmd.fail   = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.scan_next_level = 1'b1;
                    state_next          = S_SC_RD;
                end
            end
            S_AL_TAKE: begin
                cmd.al_take = 1'b1;
                state_next  = S_AL_SPLIT;
            end
            S_AL_SPLIT: begin
                if (sts.split_more) begin
                    cmd.split_step = 1'b1;
                    state_next     = S_SET_RD;
                end else begin
                    cmd.tot_alloc = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FR_CHK: begin
                if (sts.cls_big) begin
                    cmd.fail   = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.fr_init = 1'b1;
                    state_next  = S_FR_TEST;
                end
            end
            S_FR_TEST: begin
                cmd.set_node = 1'b1;
                state_next   = sts.ord_top ? S_SET_RD : S_FR_RD;
            end
            S_FR_RD: begin
                state_next = S_FR_CK;
            end
            S_FR_CK: begin
                if (sts.buddy_free) begin
                    cmd.fr_merge = 1'b1;
                    state_next   = S_FR_TEST;
                end else begin
                    state_next = S_SET_RD;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    clr_rb_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result beat valid flag.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_rb_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_rb_reg  <= clr_rb_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/bba_dp.sv
// Datapath of the buddy block allocator: registers, mark store and totals.
`default_nettype none
module bba_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [bba_pkg::SIZE_BITS-1:0]   cfg_wdata,
    input  wire bba_pkg::in_beat_t               s_data,
    input  wire bba_pkg::cmd_t                   cmd,
    output bba_pkg::sts_t                        sts,
    output bba_pkg::out_beat_t                   m_data
);

    localparam int AB = bba_pkg::ADDR_BITS;
    localparam int SB = bba_pkg::SIZE_BITS;
    localparam int NB = bba_pkg::NODE_BITS;
    localparam int OB = bba_pkg::ORD_BITS;
    localparam int WB = bba_pkg::WORD_BITS;
    localparam int WL = bba_pkg::WORD_LOG2;
    localparam int RB = bba_pkg::ROW_BITS;
    localparam int MINB = bba_pkg::MIN_BLOCK_LOG2;

    // Tree node of the block of order o at address a.
    function automatic logic [NB-1:0] node_of(input logic [OB-1:0] o,
                                              input logic [AB-1:0] a);
        logic [NB-1:0] base;
        logic [AB-1:0] sh;
        base = NB'(1) << (OB'(AB) - o);
        sh   = a >> o;
        return base + sh[NB-1:0];
    endfunction

    logic [SB-1:0] pool_start_reg, pool_end_reg;
    logic [1:0]    op_reg;
    logic [SB-1:0] size_reg;
    logic [OB-1:0] cls_reg;
    logic [OB-1:0] ord_reg, ord_next;
    logic [SB-1:0] addr_reg, addr_next;
    logic [SB-1:0] end_reg, end_next;
    logic [RB-1:0] row_reg, row_next;
    logic [NB-1:0] node_reg, node_next;
    logic [WB-1:0] rowdata_reg;
    logic [SB-1:0] alloc_tot_reg, alloc_tot_next;
    logic [31:0]   req_tot_reg, req_tot_next;
    logic [AB-1:0] res_addr_reg, res_addr_next;
    logic          res_status_reg, res_status_next;
    bba_pkg::out_beat_t out_reg;

    // Block address of the item, held for the free path.
    logic [AB-1:0] s_data_addr_reg;

    logic          ram_we;
    logic [RB-1:0] ram_waddr, ram_raddr;
    logic [WB-1:0] ram_wdata, ram_rdata;

    // Size class of the incoming request: smallest order that holds it.
    logic [OB-1:0] cls_in;
    always_comb begin
        cls_in = OB'(MINB);
        for (int c = MINB; c <= AB; c++) begin
            if (s_data.request_size > (SB'(1) << c)) begin
                cls_in = cls_in + OB'(1);
            end
        end
    end

    // Level geometry of the current order for the free-block scan.
    logic [NB-1:0] lvl_base, lvl_base_up;
    logic [NB:0]   lvl_end;
    logic [RB-1:0] first_row_up, last_row;
    logic [WB-1:0] lvl_mask, hit_vec;
    logic [WL-1:0] hit_pos;
    always_comb begin
        lvl_base     = node_of(ord_reg, '0);
        lvl_base_up  = node_of(ord_reg + OB'(1), '0);
        lvl_end      = ({1'b0, lvl_base} << 1) - (NB + 1)'(1);
        first_row_up = lvl_base_up[NB-1:WL];
        last_row     = lvl_end[NB-1:WL];
        if (lvl_base[NB-1:WL] != '0) begin
            lvl_mask = '1;
        end else begin
            lvl_mask = ((WB'(1) << lvl_base[WL-1:0]) - WB'(1)) << lvl_base[WL-1:0];
        end
        hit_vec = ram_rdata & lvl_mask;
        hit_pos = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_pos = WL'(i);
            end
        end
    end

    // Rebuild bounds and the test for growing the current block.
    logic [SB:0]   start_round, end_round;
    logic [SB-1:0] start_sat, end_sat, rem;
    logic          grow;
    always_comb begin
        start_round = ({1'b0, pool_start_reg} + (SB + 1)'((1 << MINB) - 1))
                      & ~(SB + 1)'((1 << MINB) - 1);
        end_round   = {1'b0, pool_end_reg} & ~(SB + 1)'((1 << MINB) - 1);
        start_sat   = (start_round > ((SB + 1)'(1) << AB)) ? (SB'(1) << AB)
                                                           : start_round[SB-1:0];
        end_sat     = (end_round > ((SB + 1)'(1) << AB)) ? (SB'(1) << AB)
                                                         : end_round[SB-1:0];
        rem         = end_reg - addr_reg;
        grow        = (ord_reg < OB'(AB)) && !addr_reg[ord_reg]
                      && ({1'b0, rem} >= ((SB + 1)'(1) << (ord_reg + OB'(1))));
    end

    // Node bits and the block address taken from a found node.
    logic [WB-1:0]    node_bit, buddy_bit;
    logic [NB+AB-1:0] take_wide;
    always_comb begin
        node_bit  = WB'(1) << node_reg[WL-1:0];
        buddy_bit = WB'(1) << (node_reg[WL-1:0] ^ WL'(1));
        take_wide = {{AB{1'b0}}, node_reg} << ord_reg;
    end

    // Status toward the controller.
    always_comb begin
        sts.op         = (cmd.load_item) ? s_data.operation : op_reg;
        sts.cls_big    = cls_reg > OB'(AB);
        sts.rb_more    = addr_reg < end_reg;
        sts.rb_grow    = grow;
        sts.hit        = hit_vec != '0;
        sts.row_last   = row_reg == last_row;
        sts.ord_top    = ord_reg == OB'(AB);
        sts.split_more = ord_reg > cls_reg;
        sts.buddy_free = (ram_rdata & buddy_bit) != '0;
        sts.clr_last   = row_reg == '1;
    end

    // Mark store port selection.
    always_comb begin
        ram_raddr = cmd.rd_scan ? row_reg : node_reg[NB-1:WL];
        ram_we    = cmd.clr_step | cmd.al_take | cmd.set_write | cmd.fr_merge;
        ram_waddr = cmd.clr_step ? row_reg : node_reg[NB-1:WL];
        if (cmd.clr_step) begin
            ram_wdata = '0;
        end else if (cmd.al_take) begin
            ram_wdata = rowdata_reg & ~node_bit;
        end else if (cmd.fr_merge) begin
            ram_wdata = ram_rdata & ~(node_bit | buddy_bit);
        end else begin
            ram_wdata = ram_rdata | node_bit;
        end
    end

    // Working registers: order, address, bound, row pointer and node.
    always_comb begin
        ord_next  = ord_reg;
        addr_next = addr_reg;
        end_next  = end_reg;
        row_next  = row_reg;
        node_next = node_reg;
        if (cmd.clr_start) begin
            row_next = '0;
        end
        if (cmd.clr_step) begin
            row_next = row_reg + RB'(1);
        end
        if (cmd.rb_init) begin
            addr_next = start_sat;
            end_next  = end_sat;
        end
        if (cmd.rb_ord_start) begin
            ord_next = OB'(MINB);
        end
        if (cmd.rb_grow) begin
            ord_next = ord_reg + OB'(1);
        end
        if (cmd.rb_advance) begin
            addr_next = addr_reg + (SB'(1) << ord_reg);
        end
        if (cmd.set_node) begin
            node_next = node_of(ord_reg, addr_reg[AB-1:0]);
        end
        if (cmd.scan_init) begin
            ord_next = cls_reg;
            row_next = RB'(node_of(cls_reg, '0) >> WL);
        end
        if (cmd.scan_next_row) begin
            row_next = row_reg + RB'(1);
        end
        if (cmd.scan_next_level) begin
            ord_next = ord_reg + OB'(1);
            row_next = first_row_up;
        end
        if (cmd.scan_take) begin
            node_next = {row_reg, hit_pos};
        end
        if (cmd.al_take) begin
            addr_next = {1'b0, take_wide[AB-1:0]};
        end
        if (cmd.split_step) begin
            ord_next  = ord_reg - OB'(1);
            node_next = node_of(ord_reg - OB'(1), addr_reg[AB-1:0]) | NB'(1);
        end
        if (cmd.fr_init) begin
            ord_next  = cls_reg;
            addr_next = {1'b0, s_data_addr_reg & ~((AB'(1) << cls_reg) - AB'(1))};
        end
        if (cmd.fr_merge) begin
            ord_next  = ord_reg + OB'(1);
            addr_next = addr_reg & ~(SB'(1) << ord_reg);
        end
    end

    // Totals and result fields.
    always_comb begin
        alloc_tot_next  = alloc_tot_reg;
        req_tot_next    = req_tot_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        if (cmd.load_item) begin
            res_addr_next   = '0;
            res_status_next = 1'b0;
        end
        if (cmd.clr_start) begin
            alloc_tot_next = '0;
            req_tot_next   = '0;
        end
        if (cmd.fail) begin
            res_status_next = 1'b1;
        end
        if (cmd.tot_alloc) begin
            alloc_tot_next = alloc_tot_reg + (SB'(1) << cls_reg);
            req_tot_next   = req_tot_reg + 32'(size_reg);
            res_addr_next  = addr_reg[AB-1:0];
        end
        if (cmd.tot_free) begin
            alloc_tot_next = alloc_tot_reg - (SB'(1) << cls_reg);
            req_tot_next   = req_tot_reg - 32'(size_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_start_reg <= bba_pkg::POOL_START_RST;
            pool_end_reg   <= bba_pkg::POOL_END_RST;
            row_reg        <= '0;
            alloc_tot_reg  <= '0;
            req_tot_reg    <= '0;
        end else begin
            if (cfg_we && cfg_index == bba_pkg::REG_POOL_START) begin
                pool_start_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == bba_pkg::REG_POOL_END) begin
                pool_end_reg <= cfg_wdata;
            end
            row_reg       <= row_next;
            alloc_tot_reg <= alloc_tot_next;
            req_tot_reg   <= req_tot_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg          <= s_data.operation;
            size_reg        <= s_data.request_size;
            cls_reg         <= cls_in;
            s_data_addr_reg <= s_data.block_address;
        end
        if (cmd.scan_take) begin
            rowdata_reg <= ram_rdata;
        end
        if (cmd.out_load) begin
            out_reg.result_address  <= res_addr_reg;
            out_reg.status          <= res_status_reg;
            out_reg.allocated_total <= alloc_tot_reg;
            out_reg.requested_total <= req_tot_reg;
        end
        ord_reg        <= ord_next;
        addr_reg       <= addr_next;
        end_reg        <= end_next;
        node_reg       <= node_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    assign m_data = out_reg;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (bba_pkg::ROWS)
    ) u_marks (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// File: sv/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus datapath.
//
// The input channel (s_valid, s_ready, s_data) takes one operation per beat:
// rebuild the pool from pool_start and pool_end, allocate request_size bytes,
// or free the block at block_address. Each beat yields exactly one result
// beat on the m_ channel with the block address, a status bit and the byte
// totals after the operation. The user must write configuration through
// cfg_we, cfg_index and cfg_wdata only while no operation is in flight;
// the block itself does not enforce it. Items are handled one at a time.
// Allocate scans 32-bit mark words from the request's level upward, then
// splits the found block down one level at a time to the request's order.
// Free merges the block with its buddy level by level while the buddy is free.
// Rebuild clears the 4096-word mark store one word a cycle, then places
// each pool block. After reset the same clearing pass runs with s_ready low.
// The result beat sits in an output register; a new item is accepted while
// it waits, and a finished item holds until the receiver takes the beat.
`default_nettype none
module buddy_block_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [bba_pkg::SIZE_BITS-1:0] cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bba_pkg::in_beat_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bba_pkg::out_beat_t                 m_data
);

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bba_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// File: sv/bba_checker.sv
// Port-level checks of the buddy block allocator and their binding.
`default_nettype none
module bba_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire bba_pkg::in_beat_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire bba_pkg::out_beat_t m_data
);

    // No result beat is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // A failed operation never reports an address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.result_address == '0)
        else $error("failed operation carries an address");

    // One item at a time: ready drops after an accepted beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
`default_nettype wire

// File: tb/buddy_block_allocator_tb.sv
// Self-checking testbench of the buddy block allocator with its own allocator predictor.
`timescale 1ns / 1ps
module buddy_block_allocator_tb;

    localparam int  ADDR_BITS      = bba_pkg::ADDR_BITS;
    localparam int  SIZE_BITS      = bba_pkg::SIZE_BITS;
    localparam int  MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2;
    localparam int  NODE_BITS      = bba_pkg::NODE_BITS;
    localparam logic [1:0] OP_REBUILD = bba_pkg::OP_REBUILD;
    localparam logic [1:0] OP_ALLOC   = bba_pkg::OP_ALLOC;
    localparam logic [1:0] OP_FREE    = bba_pkg::OP_FREE;
    localparam logic REG_POOL_START = bba_pkg::REG_POOL_START;
    localparam logic REG_POOL_END   = bba_pkg::REG_POOL_END;
    localparam logic [SIZE_BITS-1:0] POOL_START_RST = bba_pkg::POOL_START_RST;
    localparam logic [SIZE_BITS-1:0] POOL_END_RST   = bba_pkg::POOL_END_RST;

    typedef bba_pkg::in_beat_t  in_beat_t;
    typedef bba_pkg::out_beat_t out_beat_t;

    localparam int  NODES       = 1 << NODE_BITS;
    localparam int  CYCLE_LIMIT = 50_000_000;
    localparam int  LIVE_MAX    = 400;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we  = 1'b0;
    logic             cfg_index = REG_POOL_START;
    logic [SIZE_BITS-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_beat_t         s_data  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_beat_t        m_data;

    // Predicted allocator state.
    bit               marks [NODES];
    int               level_free [ADDR_BITS+1];
    logic [SIZE_BITS-1:0] alloc_bytes;
    logic [31:0]      req_bytes;
    logic [SIZE_BITS-1:0] start_reg;
    logic [SIZE_BITS-1:0] end_reg;

    // Results still owed by the block, oldest first.
    out_beat_t        owed_results [$];

    // Blocks handed out and not yet returned, used to build well-formed frees.
    logic [ADDR_BITS-1:0] live_addr [$];
    logic [SIZE_BITS-1:0] live_size [$];

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               recv_hold     = 0;
    int               error_count   = 0;
    int               cycle_count   = 0;

    buddy_block_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Clock: 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, or a long counted hold-off when asked.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            m_ready <= 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // Compare each result beat with the oldest owed result.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected beat", m_data, 0);
            end else begin
                want = owed_results.pop_front();
                if (m_data.result_address !== want.result_address)
                    report_mismatch("result_address", m_data.result_address,
                                    want.result_address);
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.allocated_total !== want.allocated_total)
                    report_mismatch("allocated_total", m_data.allocated_total,
                                    want.allocated_total);
                if (m_data.requested_total !== want.requested_total)
                    report_mismatch("requested_total", m_data.requested_total,
                                    want.requested_total);
            end
        end
    end

    // Tree node of a block of order ord at address addr.
    function automatic int node_at(int ord, longint addr);
        return int'(((longint'(1) << (ADDR_BITS - ord)) + (addr >> ord)) & (NODES - 1));
    endfunction

    // Order of the smallest block that holds size bytes.
    function automatic int order_for(longint size);
        int c;
        c = MIN_BLOCK_LOG2;
        while (c < 40 && (longint'(1) << c) < size) c++;
        return c;
    endfunction

    // Set or clear one mark, keeping the per-order free counts in step.
    function automatic void put_mark(int ord, int node, bit val);
        if (marks[node] != val) begin
            marks[node] = val;
            level_free[ord] += val ? 1 : -1;
        end
    endfunction

    function automatic void clear_marks();
        foreach (marks[i]) marks[i] = 1'b0;
        foreach (level_free[i]) level_free[i] = 0;
    endfunction

    // Split the configured pool into maximal aligned free blocks.
    function automatic void rebuild_pool();
        longint lo, hi, cur, rem;
        int p, o;
        clear_marks();
        alloc_bytes = '0;
        req_bytes   = '0;
        lo = (longint'(start_reg) + 15) & ~longint'(15);
        hi = longint'(end_reg) & ~longint'(15);
        if (lo > (longint'(1) << ADDR_BITS)) lo = longint'(1) << ADDR_BITS;
        if (hi > (longint'(1) << ADDR_BITS)) hi = longint'(1) << ADDR_BITS;
        cur = lo;
        while (cur < hi) begin
            rem = hi - cur;
            p = 0;
            while (p < 63 && (rem >> (p + 1)) != 0) p++;
            o = MIN_BLOCK_LOG2;
            while (o < ADDR_BITS && ((cur >> o) & 1) == 0) o++;
            if (o > p) o = p;
            if (o < MIN_BLOCK_LOG2) break;
            put_mark(o, node_at(o, cur), 1'b1);
            cur += longint'(1) << o;
        end
    endfunction

    // Lowest-address free block of the smallest sufficient order, split down.
    function automatic bit take_block(longint size, output longint addr);
        int cls, o;
        longint base;
        cls  = order_for(size);
        addr = 0;
        if (cls > ADDR_BITS) return 1'b0;
        for (o = cls; o <= ADDR_BITS; o++) begin
            if (level_free[o] > 0) begin
                base = longint'(1) << (ADDR_BITS - o);
                for (longint i = 0; i < base; i++) begin
                    if (marks[int'((base + i) & (NODES - 1))]) begin
                        addr = i << o;
                        put_mark(o, int'((base + i) & (NODES - 1)), 1'b0);
                        while (o > cls) begin
                            o--;
                            put_mark(o, node_at(o, addr + (longint'(1) << o)), 1'b1);
                        end
                        alloc_bytes = alloc_bytes + (SIZE_BITS'(1) << cls);
                        req_bytes   = req_bytes + 32'(size);
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Return a block and merge it with free buddies.
    function automatic bit return_block(longint size, longint addr);
        int cls, o, n;
        cls = order_for(size);
        if (cls > ADDR_BITS) return 1'b0;
        addr &= (longint'(1) << ADDR_BITS) - 1;
        addr &= ~((longint'(1) << cls) - 1);
        o = cls;
        while (o < ADDR_BITS) begin
            n = node_at(o, addr);
            if (!marks[n ^ 1]) break;
            put_mark(o, n ^ 1, 1'b0);
            put_mark(o, n, 1'b0);
            addr &= ~(longint'(1) << o);
            o++;
        end
        put_mark(o, node_at(o, addr), 1'b1);
        alloc_bytes = alloc_bytes - (SIZE_BITS'(1) << cls);
        req_bytes   = req_bytes - 32'(size);
        return 1'b1;
    endfunction

    // Work out the result of one accepted beat.
    function automatic out_beat_t predict_result(in_beat_t b);
        out_beat_t r;
        longint addr;
        r = '0;
        case (b.operation)
            OP_REBUILD: begin
                rebuild_pool();
            end
            OP_ALLOC: begin
                if (take_block(b.request_size, addr)) r.result_address = addr[ADDR_BITS-1:0];
                else r.status = 1'b1;
            end
            OP_FREE: begin
                if (!return_block(b.request_size, b.block_address)) r.status = 1'b1;
            end
            default: ;
        endcase
        r.allocated_total = alloc_bytes;
        r.requested_total = req_bytes;
        return r;
    endfunction

    // Offer one beat, with random sender gaps, and record its result once taken.
    task automatic send_beat(input logic [1:0] op, input logic [SIZE_BITS-1:0] size,
                             input logic [ADDR_BITS-1:0] addr);
        in_beat_t  b;
        out_beat_t r;
        b.operation     = op;
        b.request_size  = size;
        b.block_address = addr;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 99) < send_idle_pct) s_valid <= 1'b0;
            else break;
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        r = predict_result(b);
        owed_results.push_back(r);
        if (op == OP_ALLOC && !r.status && live_addr.size() < LIVE_MAX) begin
            live_addr.push_back(r.result_address);
            live_size.push_back(size);
        end
    endtask

    // Drop valid and let every owed result come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [SIZE_BITS-1:0] val);
        @(negedge aclk);
        s_valid   <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_POOL_START) start_reg = val;
        else start_reg = start_reg;
        if (idx == REG_POOL_END) end_reg = val;
    endtask

    // New pool bounds followed by a rebuild.
    task automatic set_pool(input logic [SIZE_BITS-1:0] lo, input logic [SIZE_BITS-1:0] hi);
        drain_results();
        write_reg(REG_POOL_START, lo);
        write_reg(REG_POOL_END, hi);
        live_addr.delete();
        live_size.delete();
        send_beat(OP_REBUILD, SIZE_BITS'($urandom), ADDR_BITS'($urandom));
    endtask

    // Free one live block, sometimes from a misaligned address.
    task automatic free_live();
        int k;
        longint span;
        logic [ADDR_BITS-1:0] a;
        k = $urandom_range(0, live_addr.size() - 1);
        a = live_addr[k];
        span = longint'(1) << order_for(live_size[k]);
        if ($urandom_range(0, 9) == 0) a = a + ADDR_BITS'($urandom_range(0, int'(span) - 1));
        send_beat(OP_FREE, live_size[k], a);
        live_addr.delete(k);
        live_size.delete(k);
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return SIZE_BITS'($urandom_range(0, 64));
            6, 7, 8:          return SIZE_BITS'($urandom_range(0, 4096));
            default:          return SIZE_BITS'($urandom_range(0, 1 << $urandom_range(12, 20)));
        endcase
    endfunction

    // Default pool, tiny, rounded, oversized and whole-window sizes.
    task automatic test_size_edges();
        set_pool(POOL_START_RST, POOL_END_RST);
        send_beat(OP_ALLOC, 21'd0, '0);
        send_beat(OP_ALLOC, 21'd16, '0);
        send_beat(OP_ALLOC, 21'd17, '1);
        send_beat(OP_ALLOC, 21'd1048576, '0);
        send_beat(OP_ALLOC, 21'h1FFFFF, '0);
        send_beat(OP_FREE, 21'h1FFFFF, '1);
        send_beat(2'd3, 21'h1FFFFF, '1);
        // Return everything so the window merges back into the top block.
        while (live_addr.size() != 0) free_live();
        send_beat(OP_ALLOC, 21'd1048576, '0);
        send_beat(OP_ALLOC, 21'd1, '0);
        send_beat(OP_FREE, 21'd1048576, 20'hFFFFF);
        send_beat(OP_FREE, 21'd5, 20'h0000F);
    endtask

    // Empty, saturated and unaligned pool bounds.
    task automatic test_pool_bounds();
        set_pool(21'd4096, 21'd1024);
        send_beat(OP_ALLOC, 21'd16, '0);
        set_pool(21'h1FFFFF, 21'h1FFFFF);
        send_beat(OP_ALLOC, 21'd16, '0);
        set_pool(21'd17, 21'd1000003);
        send_beat(OP_ALLOC, 21'd300000, '0);
        send_beat(OP_ALLOC, 21'd8, '0);
        set_pool(21'd0, 21'h1FFFFF);
        send_beat(OP_ALLOC, 21'd524288, '0);
    endtask

    // Receiver holds off while beats keep coming; then the sender waits for all results.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 3000;
        repeat (6) send_beat(OP_ALLOC, pick_size(), '0);
        drain_results();
        repeat (4) if (live_addr.size() != 0) free_live();
        drain_results();
    endtask

    // Random mix of well-formed allocate/free sequences with some noise.
    task automatic test_random(input int count, input int s_idle, input int r_idle);
        int r;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        set_pool(SIZE_BITS'($urandom_range(0, 1 << 16)),
                 SIZE_BITS'($urandom_range(1 << 19, (1 << 20) + 64)));
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r == 0) begin
                live_addr.delete();
                live_size.delete();
                send_beat(OP_REBUILD, SIZE_BITS'($urandom), ADDR_BITS'($urandom));
            end else if (r < 3) begin
                send_beat(2'($urandom_range(2, 3)), SIZE_BITS'($urandom), ADDR_BITS'($urandom));
            end else if (r < 48 && live_addr.size() != 0) begin
                free_live();
            end else begin
                send_beat(OP_ALLOC, pick_size(), ADDR_BITS'($urandom));
            end
        end
    endtask

    initial begin
        clear_marks();
        alloc_bytes = '0;
        req_bytes   = '0;
        start_reg   = POOL_START_RST;
        end_reg     = POOL_END_RST;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        recv_idle_pct = 20;
        test_size_edges();
        test_pool_bounds();
        test_backpressure();
        test_random(360, 13, 75);
        test_random(360, 75, 13);
        test_random(360, 0, 0);

        drain_results();
        repeat (100) @(posedge aclk);
        if (error_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_ctrl.sv
sv/bba_dp.sv
sv/buddy_block_allocator.sv
sv/bba_checker.sv
tb/buddy_block_allocator_tb.sv
